// ===== rtl/core/assert_macros.svh =====
// assertion macros for the 1-wire sensor sequencer
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/owts_pkg.sv =====
// shared types, codes and constants of the 1-wire sensor sequencer
// no dependencies
`timescale 1ns / 1ps

package owts_pkg;

	localparam int SCRATCH_BYTES_DEF = 9;

	// bus command codes
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// device opcodes
	localparam logic [7:0] OP_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] OP_CONVERT   = 8'h44;
	localparam logic [7:0] OP_WRITE_PAD = 8'h4E;
	localparam logic [7:0] OP_READ_PAD  = 8'hBE;

	// configuration register indexes and reset values
	localparam logic [1:0] REG_ALARM_HIGH = 2'd0;
	localparam logic [1:0] REG_ALARM_LOW  = 2'd1;
	localparam logic [1:0] REG_RESOLUTION = 2'd2;
	localparam logic [7:0] ALARM_HIGH_RST = 8'h32;
	localparam logic [7:0] ALARM_LOW_RST  = 8'h85;
	localparam logic [7:0] RESOLUTION_RST = 8'h7F;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_PRESENCE = 4'd1,
		ST_SKIPROM  = 4'd2,
		ST_CFG_PRE  = 4'd3,
		ST_CFG_HIGH = 4'd4,
		ST_CFG_LOW  = 4'd5,
		ST_CFG_RES  = 4'd6,
		ST_CONVERT  = 4'd7,
		ST_READ_PAD = 4'd8,
		ST_ACQUIRE  = 4'd9,
		ST_ERROR    = 4'd10
	} state_t;

	typedef struct packed {
		logic configuring;
		logic reading;
		logic conv_done;
		logic temp_ready;
		logic configured;
	} flags_t;

	typedef struct packed {
		logic [7:0] alarm_high;
		logic [7:0] alarm_low;
		logic [7:0] resolution;
	} cfg_regs_t;

	typedef struct packed {
		logic       configure_request;
		logic       start_request;
		logic       ready_clear;
		logic       bus_idle;
		logic       presence_ok;
		logic       sampled_bit;
		logic [7:0] received_byte;
	} item_t;

endpackage

// ===== rtl/core/owts_scratch.sv =====
// scratchpad byte store, written one byte per step
// depends on owts_pkg; provides the next temperature word from bytes one and zero
`timescale 1ns / 1ps

module owts_scratch #(
	parameter int SCRATCH_BYTES = owts_pkg::SCRATCH_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             write_en,
	input  logic [$clog2(SCRATCH_BYTES)-1:0] write_idx,
	input  logic [7:0]                       write_byte,
	output logic [15:0]                      temp_next
);
	import owts_pkg::*;

	localparam int CW = $clog2(SCRATCH_BYTES);

	logic [7:0] bytes_q [SCRATCH_BYTES];
	logic [7:0] byte0_next;
	logic [7:0] byte1_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCRATCH_BYTES; i++) begin
				bytes_q[i] <= '0;
			end
		end else if (write_en) begin
			bytes_q[write_idx] <= write_byte;
		end
	end

	// bypass so the word reflects a byte stored in this step
	assign byte0_next = (write_en && write_idx == CW'(0)) ? write_byte : bytes_q[0];
	assign byte1_next = (write_en && write_idx == CW'(1)) ? write_byte : bytes_q[1];
	assign temp_next  = {byte1_next, byte0_next};

endmodule

// ===== rtl/core/owts_step.sv =====
// one step of the sequencer state machine: request strobes, then the state step
// depends on owts_pkg
`timescale 1ns / 1ps

module owts_step #(
	parameter int SCRATCH_BYTES = owts_pkg::SCRATCH_BYTES_DEF
) (
	input  owts_pkg::state_t                 state,
	input  owts_pkg::flags_t                 flags,
	input  logic [$clog2(SCRATCH_BYTES)-1:0] count,
	input  owts_pkg::item_t                  item,
	input  owts_pkg::cfg_regs_t              cfg,
	output owts_pkg::state_t                 state_next,
	output owts_pkg::flags_t                 flags_next,
	output logic [$clog2(SCRATCH_BYTES)-1:0] count_next,
	output logic [1:0]                       cmd,
	output logic [7:0]                       data,
	output logic                             store_we
);
	import owts_pkg::*;

	localparam int CW = $clog2(SCRATCH_BYTES);
	localparam logic [CW-1:0] LAST = CW'(SCRATCH_BYTES - 1);

	flags_t req;
	logic   busy;

	// request strobes
	always_comb begin
		req = flags;
		busy = flags.configuring || flags.conv_done || flags.reading;
		if (item.configure_request && !flags.configured) begin
			req.configuring = 1'b1;
		end
		if (item.start_request && flags.configured && !busy) begin
			req.reading = 1'b1;
		end
		if (item.ready_clear) begin
			req.temp_ready = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_next = state;
		case (state)
			ST_IDLE: begin
				if (req.configuring || req.reading) state_next = ST_PRESENCE;
			end
			ST_PRESENCE: begin
				if (item.bus_idle) state_next = item.presence_ok ? ST_SKIPROM : ST_ERROR;
			end
			ST_SKIPROM: begin
				if (item.bus_idle) begin
					if (req.configuring) state_next = ST_CFG_PRE;
					else if (req.reading) state_next = ST_CONVERT;
					else if (req.conv_done) state_next = ST_READ_PAD;
				end
			end
			ST_CONVERT: begin
				if (item.bus_idle && item.sampled_bit) state_next = ST_PRESENCE;
			end
			ST_READ_PAD: begin
				if (item.bus_idle) state_next = ST_ACQUIRE;
			end
			ST_ACQUIRE: begin
				if (item.bus_idle && count == LAST) state_next = ST_IDLE;
			end
			ST_CFG_PRE: begin
				if (item.bus_idle) state_next = ST_CFG_HIGH;
			end
			ST_CFG_HIGH: begin
				if (item.bus_idle) state_next = ST_CFG_LOW;
			end
			ST_CFG_LOW: begin
				if (item.bus_idle) state_next = ST_CFG_RES;
			end
			ST_CFG_RES: begin
				if (item.bus_idle) state_next = ST_IDLE;
			end
			default: begin
				state_next = state;
			end
		endcase
	end

	// outputs, flags and byte counter
	always_comb begin
		flags_next = req;
		count_next = count;
		cmd        = CMD_NONE;
		data       = '0;
		store_we   = 1'b0;
		case (state)
			ST_IDLE: begin
				if (req.configuring || req.reading) cmd = CMD_RESET;
			end
			ST_PRESENCE: begin
				if (item.bus_idle && item.presence_ok) begin
					cmd  = CMD_WRITE;
					data = OP_SKIP_ROM;
				end
			end
			ST_SKIPROM: begin
				if (item.bus_idle) begin
					if (req.configuring) begin
						cmd  = CMD_WRITE;
						data = OP_WRITE_PAD;
					end else if (req.reading) begin
						cmd  = CMD_WRITE;
						data = OP_CONVERT;
					end else if (req.conv_done) begin
						flags_next.conv_done = 1'b0;
						cmd  = CMD_WRITE;
						data = OP_READ_PAD;
					end
				end
			end
			ST_CONVERT: begin
				if (item.bus_idle && item.sampled_bit) begin
					flags_next.conv_done = 1'b1;
					flags_next.reading   = 1'b0;
					cmd = CMD_RESET;
				end
			end
			ST_READ_PAD: begin
				if (item.bus_idle) begin
					cmd        = CMD_READ;
					count_next = '0;
				end
			end
			ST_ACQUIRE: begin
				if (item.bus_idle) begin
					store_we = 1'b1;
					if (count == LAST) begin
						count_next            = '0;
						flags_next.reading    = 1'b0;
						flags_next.temp_ready = 1'b1;
					end else begin
						count_next = count + CW'(1);
						cmd        = CMD_READ;
					end
				end
			end
			ST_CFG_PRE: begin
				if (item.bus_idle) begin
					cmd  = CMD_WRITE;
					data = cfg.alarm_high;
				end
			end
			ST_CFG_HIGH: begin
				if (item.bus_idle) begin
					cmd  = CMD_WRITE;
					data = cfg.alarm_low;
				end
			end
			ST_CFG_LOW: begin
				if (item.bus_idle) begin
					cmd  = CMD_WRITE;
					data = cfg.resolution;
				end
			end
			ST_CFG_RES: begin
				if (item.bus_idle) begin
					flags_next.configuring = 1'b0;
					flags_next.configured  = 1'b1;
				end
			end
			default: begin
				cmd = CMD_NONE;
			end
		endcase
	end

endmodule

// ===== rtl/core/onewire_temp_sensor_sequencer_unit.sv =====
// top level of the 1-wire temperature sensor sequencer
// depends on owts_pkg, owts_step, owts_scratch and assert_macros.svh
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// input    | in        | in_valid / in_ready  | request strobes, bus status, received byte
// result   | out       | out_valid / out_ready| bus command, write data, temperature, flags
// config   | in        | cfg_write_enable     | cfg_index, cfg_data
//
// one transaction per cycle unless out_ready stalls; input register, result register
// the state step is one pass of the state machine between the two registers
// reset clears state, flags, scratchpad, byte counter and loads the register defaults
// a stalled result holds the input register, which then holds in_ready low
`timescale 1ns / 1ps

`include "assert_macros.svh"

module onewire_temp_sensor_sequencer_unit #(
	parameter int SCRATCH_BYTES = owts_pkg::SCRATCH_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               configure_request,
	input  logic               start_request,
	input  logic               ready_clear,
	input  logic               bus_idle,
	input  logic               presence_ok,
	input  logic               sampled_bit,
	input  logic [7:0]         received_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         bus_command,
	output logic [7:0]         write_data,
	output logic signed [15:0] temperature,
	output logic               temperature_ready,
	output logic               is_configured,
	output logic               is_busy,
	output logic               error_stuck,
	input  logic               cfg_write_enable,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import owts_pkg::*;

	localparam int CW = $clog2(SCRATCH_BYTES);

	cfg_regs_t   cfg_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	state_t      state_q;
	state_t      state_next;
	flags_t      flags_q;
	flags_t      flags_next;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [1:0]  cmd;
	logic [7:0]  data;
	logic        store_we;
	logic [15:0] temp_next;
	logic        out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_high <= ALARM_HIGH_RST;
			cfg_q.alarm_low  <= ALARM_LOW_RST;
			cfg_q.resolution <= RESOLUTION_RST;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				REG_ALARM_HIGH: cfg_q.alarm_high <= cfg_data;
				REG_ALARM_LOW:  cfg_q.alarm_low  <= cfg_data;
				REG_RESOLUTION: cfg_q.resolution <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{configure_request: configure_request,
				start_request: start_request,
				ready_clear: ready_clear,
				bus_idle: bus_idle,
				presence_ok: presence_ok,
				sampled_bit: sampled_bit,
				received_byte: received_byte};
		end
	end

	owts_step #(
		.SCRATCH_BYTES(SCRATCH_BYTES)
	) u_step (
		.state      (state_q),
		.flags      (flags_q),
		.count      (count_q),
		.item       (item_s1),
		.cfg        (cfg_q),
		.state_next (state_next),
		.flags_next (flags_next),
		.count_next (count_next),
		.cmd        (cmd),
		.data       (data),
		.store_we   (store_we)
	);

	owts_scratch #(
		.SCRATCH_BYTES(SCRATCH_BYTES)
	) u_scratch (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (advance && store_we),
		.write_idx  (count_q),
		.write_byte (item_s1.received_byte),
		.temp_next  (temp_next)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flags_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
			flags_q <= flags_next;
			count_q <= count_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bus_command       <= cmd;
			write_data        <= data;
			temperature       <= $signed(temp_next);
			temperature_ready <= flags_next.temp_ready;
			is_configured     <= flags_next.configured;
			is_busy           <= flags_next.configuring || flags_next.conv_done
				|| flags_next.reading;
			error_stuck       <= (state_next == ST_ERROR);
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_error_terminal, clk, arst_n, state_q == ST_ERROR, state_q == ST_ERROR)
	`ASSERT_NEXT(a_configured_sticky, clk, arst_n, flags_q.configured, flags_q.configured)
	`ASSERT_IMPL(a_count_in_acquire, clk, arst_n, count_q != '0, state_q == ST_ACQUIRE)
	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, valid_s1 && out_valid_q && !out_ready, valid_s1)

endmodule
